// File: rtl/rkd_pkg.sv
// ----------------------------------------------------------------------------
// rkd_pkg
// Shared types, constants and helper functions of the remote key debouncer.
// ----------------------------------------------------------------------------
package rkd_pkg;

  // Button count and fixed widths
  localparam int NumButtonsDefault = 4;
  localparam int MaskBits          = 4;   // width of the per-button result masks
  localparam int HistBits          = 8;   // debounce history per button
  localparam int CountBits         = 4;   // holds 0..HistBits
  localparam int CodeBits          = 8;
  localparam int TimeBits          = 32;
  localparam int TimeoutBits       = 8;
  localparam int ThrBits           = 4;
  localparam int CfgIndexBits      = 8;
  localparam int CfgDataBits       = 8;

  // Sleep timeout unit: 5 s in milliseconds
  localparam int SleepUnitMs = 5 * 1000;
  localparam int UnitBits    = 13;
  localparam int LimitBits   = TimeoutBits + UnitBits;

  // Remote key codes
  localparam logic [CodeBits-1:0] KeyRepeat  = 8'h00;
  localparam logic [CodeBits-1:0] KeyBtn0A   = 8'h98;
  localparam logic [CodeBits-1:0] KeyBtn0B   = 8'h90;
  localparam logic [CodeBits-1:0] KeyBtn1    = 8'ha8;
  localparam logic [CodeBits-1:0] KeyBtn2A   = 8'h02;
  localparam logic [CodeBits-1:0] KeyBtn2B   = 8'he0;
  localparam logic [CodeBits-1:0] KeyBtn3    = 8'ha2;

  // Configuration register indexes
  typedef enum logic [CfgIndexBits-1:0] {
    CfgSleepTimeout    = 8'd0,
    CfgPressThreshold  = 8'd1,
    CfgReleaseThreshold = 8'd2,
    CfgHandlerEnable   = 8'd3
  } cfg_reg_e;

  // Item operations
  localparam logic OpPoll = 1'b0;
  localparam logic OpWake = 1'b1;

  typedef struct packed {
    logic                operation;
    logic                ir_valid;
    logic [CodeBits-1:0] ir_code;
    logic [TimeBits-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [MaskBits-1:0] press_events;
    logic [MaskBits-1:0] held_mask;
    logic                active;
  } out_item_t;

  // Control handed to each button cell
  typedef struct packed {
    logic                 advance;
    logic                 wake;
    logic                 pressed;
    logic                 fire_en;
    logic [ThrBits-1:0]   press_thr;
    logic [ThrBits-1:0]   release_thr;
    logic [TimeBits-1:0]  now_ms;
    logic [LimitBits-1:0] limit;
  } rkd_ctrl_t;

  // Status returned by each button cell, after the update
  typedef struct packed {
    logic held;
    logic event_fired;
    logic recent;
  } rkd_stat_t;

  // Map a key code to a one-hot button select; unknown codes select nothing
  function automatic logic [MaskBits-1:0] key_to_onehot(logic [CodeBits-1:0] code);
    logic [MaskBits-1:0] sel;
    sel = '0;
    case (code)
      KeyBtn0A, KeyBtn0B: sel = 4'b0001;
      KeyBtn1:            sel = 4'b0010;
      KeyBtn2A, KeyBtn2B: sel = 4'b0100;
      KeyBtn3:            sel = 4'b1000;
      default:            sel = '0;
    endcase
    return sel;
  endfunction

  function automatic logic [CountBits-1:0] ones(logic [HistBits-1:0] v);
    logic [CountBits-1:0] n;
    n = '0;
    for (int k = 0; k < HistBits; k++) begin
      n = n + CountBits'(v[k]);
    end
    return n;
  endfunction

endpackage

// File: rtl/rkd_button.sv
// ----------------------------------------------------------------------------
// rkd_button
// One button: shift history, press/release hysteresis, latch and fire flags,
// press timestamp and its sleep-timeout check.
// ----------------------------------------------------------------------------
module rkd_button
  import rkd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  rkd_ctrl_t ctrl_i,
  output rkd_stat_t stat_o
);

  logic [HistBits-1:0] history_q, history_d;
  logic                latched_q, latched_d;
  logic                fired_q, fired_d;
  logic [TimeBits-1:0] press_time_q, press_time_d;
  logic [HistBits-1:0] hist_shift;
  logic [HistBits-1:0] hist_press;
  logic                event_fired;
  logic [TimeBits-1:0] age;

  assign hist_shift = {history_q[HistBits-2:0], 1'b0};
  assign hist_press = hist_shift | HistBits'(1);

  always_comb begin
    history_d    = hist_shift;
    latched_d    = latched_q;
    fired_d      = fired_q;
    press_time_d = press_time_q;
    event_fired  = 1'b0;
    if (ctrl_i.wake) begin
      history_d    = HistBits'(1);
      latched_d    = 1'b1;
      fired_d      = 1'b1;
      press_time_d = ctrl_i.now_ms;
    end else if (ctrl_i.pressed) begin
      history_d = hist_press;
      if (ones(hist_press) >= ctrl_i.press_thr) begin
        if (!latched_q) begin
          press_time_d = ctrl_i.now_ms;
          latched_d    = 1'b1;
        end
        if (!fired_q && ctrl_i.fire_en) begin
          fired_d     = 1'b1;
          event_fired = 1'b1;
        end
      end
    end else if (ones(hist_shift) <= ctrl_i.release_thr) begin
      latched_d = 1'b0;
      fired_d   = 1'b0;
    end
  end

  assign age = ctrl_i.now_ms - press_time_d;

  assign stat_o.held        = latched_d;
  assign stat_o.event_fired = event_fired;
  assign stat_o.recent      = (age < TimeBits'(ctrl_i.limit));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      history_q    <= '0;
      latched_q    <= 1'b0;
      fired_q      <= 1'b0;
      press_time_q <= '0;
    end else if (ctrl_i.advance) begin
      history_q    <= history_d;
      latched_q    <= latched_d;
      fired_q      <= fired_d;
      press_time_q <= press_time_d;
    end
  end

endmodule

// File: rtl/remote_key_debouncer.sv
// ----------------------------------------------------------------------------
// remote_key_debouncer
// Debounces remote-control key codes into per-button press events.
// ----------------------------------------------------------------------------
// Each input transfer is one poll tick (or a wake command) carrying an optional
// remote key code and the millisecond time; every input transfer yields exactly
// one result transfer with the press events fired on that tick, the mask of
// latched buttons and the sleep-timeout activity flag. The block takes one item
// per clock cycle while the input is not stalled. An item waits in the input
// register, then the key decode, history shift, popcount thresholds and timeout
// compare fill the result register in a single pass, from which it is offered.
// A full result register that is stalled stalls the input only when the input
// register is also occupied, so both sides keep moving at full rate otherwise.
// Key code 0 repeats the last received code. Configuration writes are always
// ready and take effect at once; write them only while no item is in flight.
// Register 0 is the sleep timeout in 5 s units (0 keeps the block always
// active), 1 the press threshold, 2 the release threshold and 3 the handler
// enable mask. Writes to other indexes are dropped.
module remote_key_debouncer
  import rkd_pkg::*;
#(
  parameter int NUM_BUTTONS = NumButtonsDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Input channel
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  in_item_t                in_item_i,
  // Result channel
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output out_item_t               out_item_o,
  // Configuration write channel
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CfgIndexBits-1:0] cfg_index_i,
  input  logic [CfgDataBits-1:0]  cfg_data_i
);

  localparam int PadBits = (NUM_BUTTONS > MaskBits) ? NUM_BUTTONS : MaskBits;

  // Configuration state; the sleep timeout is kept as its limit in ms
  logic [LimitBits-1:0] limit_q;
  logic [ThrBits-1:0]   press_thr_q;
  logic [ThrBits-1:0]   release_thr_q;
  logic [MaskBits-1:0]  handler_en_q;

  // Pipeline registers
  logic                 in_valid_q;
  in_item_t             in_q;
  logic                 out_valid_q;
  out_item_t            out_q;
  logic [CodeBits-1:0]  last_code_q;

  logic                 out_free;
  logic                 advance;
  logic                 in_take;
  logic                 poll_code;
  logic [CodeBits-1:0]  code_eff;
  logic [MaskBits-1:0]  key_sel;

  rkd_ctrl_t               ctrl   [NUM_BUTTONS];
  rkd_stat_t               stat   [NUM_BUTTONS];
  logic [PadBits-1:0]      key_pad;
  logic [PadBits-1:0]      en_pad;
  logic [NUM_BUTTONS-1:0]  event_vec;
  logic [NUM_BUTTONS-1:0]  held_vec;
  logic [NUM_BUTTONS-1:0]  recent_vec;
  logic [PadBits-1:0]      event_pad;
  logic [PadBits-1:0]      held_pad;
  out_item_t               result;

  // Handshake: the result register frees when empty or taken this cycle;
  // the input register moves on whenever the result register frees.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q       <= '0;
      press_thr_q   <= ThrBits'(1);
      release_thr_q <= ThrBits'(1);
      handler_en_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CfgSleepTimeout: begin
          limit_q <= LimitBits'(cfg_data_i) * LimitBits'(SleepUnitMs);
        end
        CfgPressThreshold:   press_thr_q   <= cfg_data_i[ThrBits-1:0];
        CfgReleaseThreshold: release_thr_q <= cfg_data_i[ThrBits-1:0];
        CfgHandlerEnable:    handler_en_q  <= cfg_data_i[MaskBits-1:0];
        default: ;
      endcase
    end
  end

  // Key decode: substitute the last code on a repeat, then select a button
  assign poll_code = (in_q.operation == OpPoll) && in_q.ir_valid;
  assign code_eff  = (in_q.ir_code == KeyRepeat) ? last_code_q : in_q.ir_code;
  assign key_sel   = poll_code ? key_to_onehot(code_eff) : '0;

  // Only the first buttons have key codes and handler bits; pad the rest
  assign key_pad = PadBits'(key_sel);
  assign en_pad  = PadBits'(handler_en_q);

  // Per-button cells
  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_btn
    always_comb begin
      ctrl[i].advance     = advance;
      ctrl[i].wake        = (in_q.operation == OpWake);
      ctrl[i].pressed     = key_pad[i];
      ctrl[i].fire_en     = en_pad[i];
      ctrl[i].press_thr   = press_thr_q;
      ctrl[i].release_thr = release_thr_q;
      ctrl[i].now_ms      = in_q.now_ms;
      ctrl[i].limit       = limit_q;
    end

    rkd_button u_button (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl[i]),
      .stat_o (stat[i])
    );

    assign event_vec[i]  = stat[i].event_fired;
    assign held_vec[i]   = stat[i].held;
    assign recent_vec[i] = stat[i].recent;
  end

  // Assemble the result; masks show the first four buttons only
  assign event_pad = PadBits'(event_vec);
  assign held_pad  = PadBits'(held_vec);

  always_comb begin
    result.press_events = event_pad[MaskBits-1:0];
    result.held_mask    = held_pad[MaskBits-1:0];
    result.active       = (limit_q == '0) || (|recent_vec);
  end

  // Control registers: input and result valid, last received code
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      last_code_q <= '0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      // Hold the code after repeat substitution, mapped or not
      if (advance && poll_code) begin
        last_code_q <= code_eff;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_item_i;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // A button can only fire while its press is latched
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_q.press_events & ~out_q.held_mask) == '0))
    else $error("press event on a button that is not held");

  // A wake command never fires events and its result is valid; wake also holds every shown button
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_q.operation == OpWake) |=>
      (out_q.press_events == '0) && out_valid_q)
    else $error("wake command produced press events");

  // With the sleep timeout off, every result reports active
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && limit_q == '0) |=> out_q.active)
    else $error("inactive result with sleep timeout disabled");

  // The input register must not be overwritten while it still waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_q)))
    else $error("pending item lost in the input register");

endmodule
